// File: design/draw_command_clip_window_top_macros.svh
// Assertion macros for the draw command clip window block.
// Included by the top module, which carries the concurrent assertions; no other dependencies.
`ifndef DRAW_COMMAND_CLIP_WINDOW_TOP_MACROS_SVH
`define DRAW_COMMAND_CLIP_WINDOW_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define DCCW_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dccw implication check failed");
// Next-cycle implication, disabled during reset
`define DCCW_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dccw next-cycle check failed");
`else
`define DCCW_ASSERT_IMP(label, clk, rstn, ante, cons)
`define DCCW_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: design/dccw_pkg.sv
// Shared types, constants and helper functions for the draw command clip window.
// No dependencies; used by every module of the block.
package dccw_pkg;

    // Command kinds, same encoding on input and result
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_HLINE = 2'd1,
        KIND_VLINE = 2'd2,
        KIND_RECT  = 2'd3
    } cmd_kind_e;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_TOP    = 2'd1,
        REG_CLIP_RIGHT  = 2'd2,
        REG_CLIP_BOTTOM = 2'd3
    } cfg_index_e;

    localparam int CoordW = 16;
    localparam int ExtW   = CoordW + 2;

    // Reset values of the clip window
    localparam logic signed [CoordW-1:0] CLIP_LEFT_RST   = 16'sd0;
    localparam logic signed [CoordW-1:0] CLIP_TOP_RST    = 16'sd0;
    localparam logic signed [CoordW-1:0] CLIP_RIGHT_RST  = 16'sd130;
    localparam logic signed [CoordW-1:0] CLIP_BOTTOM_RST = 16'sd130;

    // Widened signed coordinate, holds any sum or difference of two coordinates
    typedef logic signed [ExtW-1:0] ext_t;

    localparam ext_t LEN_MAX = 18'sd65535;

    typedef struct packed {
        logic signed [CoordW-1:0] left;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] right;
        logic signed [CoordW-1:0] bottom;
    } window_t;

    typedef struct packed {
        cmd_kind_e                kind;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] span_w;
        logic signed [CoordW-1:0] span_h;
        logic        [CoordW-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic                     draw;
        cmd_kind_e                out_type;
        logic signed [CoordW-1:0] out_x;
        logic signed [CoordW-1:0] out_y;
        logic        [CoordW-1:0] out_w;
        logic        [CoordW-1:0] out_h;
        logic        [CoordW-1:0] out_color;
    } result_t;

    // Sign-extend a coordinate to the wide type
    function automatic ext_t sx(input logic signed [CoordW-1:0] v);
        return {{(ExtW-CoordW){v[CoordW-1]}}, v};
    endfunction

    // Clamp a length to [0, 65535]
    function automatic logic [CoordW-1:0] sat_len(input ext_t v);
        logic [CoordW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > LEN_MAX) begin
            r = '1;
        end else begin
            r = v[CoordW-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/dccw_cfg_regs.sv
// Clip window register file, written through the configuration channel.
// Depends on dccw_pkg.
module dccw_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output dccw_pkg::window_t   window
);
    import dccw_pkg::*;

    window_t win_reg;
    window_t win_next;

    assign cfg_ready = 1'b1;
    assign window    = win_reg;

    // Register select
    always_comb begin
        win_next = win_reg;
        if (cfg_valid) begin
            case (cfg_index_e'(cfg_index))
                REG_CLIP_LEFT:   win_next.left   = cfg_data;
                REG_CLIP_TOP:    win_next.top    = cfg_data;
                REG_CLIP_RIGHT:  win_next.right  = cfg_data;
                REG_CLIP_BOTTOM: win_next.bottom = cfg_data;
                default:         win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.left   <= CLIP_LEFT_RST;
            win_reg.top    <= CLIP_TOP_RST;
            win_reg.right  <= CLIP_RIGHT_RST;
            win_reg.bottom <= CLIP_BOTTOM_RST;
        end else begin
            win_reg <= win_next;
        end
    end

endmodule

// File: design/dccw_clip_core.sv
// Combinational scissor logic: clips one draw command against the window.
// Depends on dccw_pkg.
module dccw_clip_core (
    input  dccw_pkg::cmd_t    cmd,
    input  dccw_pkg::window_t window,
    output dccw_pkg::result_t res
);
    import dccw_pkg::*;

    ext_t x, y, w, h;
    ext_t lft, top, rgt, bot;
    ext_t x_end, y_end;
    ext_t x_lo, y_lo;       // start clamped to the low bound
    ext_t x_hi, y_hi;       // end clamped to the high bound
    logic x_in, y_in;
    logic hrun_keep, vrun_keep;
    logic keep;
    ext_t ox, oy, ow, oh;

    assign x   = sx(cmd.pos_x);
    assign y   = sx(cmd.pos_y);
    assign w   = sx(cmd.span_w);
    assign h   = sx(cmd.span_h);
    assign lft = sx(window.left);
    assign top = sx(window.top);
    assign rgt = sx(window.right);
    assign bot = sx(window.bottom);

    assign x_end = x + w;
    assign y_end = y + h;
    assign x_lo  = (x < lft) ? lft : x;
    assign y_lo  = (y < top) ? top : y;
    assign x_hi  = (x_end > rgt) ? rgt : x_end;
    assign y_hi  = (y_end > bot) ? bot : y_end;

    assign x_in = (lft <= x) && (x <= rgt);
    assign y_in = (top <= y) && (y <= bot);

    // Run trim: dropped if it ends before the low bound, or if it overruns
    // the high bound while starting beyond it
    assign hrun_keep = !((x < lft) && (x_end < lft)) && !((rgt < x_end) && (rgt < x_lo));
    assign vrun_keep = !((y < top) && (y_end < top)) && !((bot < y_end) && (bot < y_lo));

    // Per-kind selection
    always_comb begin
        keep = 1'b0;
        ox   = x;
        oy   = y;
        ow   = '0;
        oh   = '0;
        case (cmd.kind)
            KIND_PIXEL: begin
                keep = x_in && y_in;
            end
            KIND_HLINE: begin
                keep = y_in && hrun_keep;
                ox   = x_lo;
                ow   = x_hi - x_lo;
            end
            KIND_VLINE: begin
                keep = x_in && vrun_keep;
                oy   = y_lo;
                oh   = y_hi - y_lo;
            end
            KIND_RECT: begin
                keep = (x <= rgt) && (x_end >= lft) && (y <= bot) && (y_end >= top);
                ox   = x_lo;
                oy   = y_lo;
                ow   = x_hi - x_lo;
                oh   = y_hi - y_lo;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Dropped commands carry only their kind
    always_comb begin
        res.draw     = keep;
        res.out_type = cmd.kind;
        if (keep) begin
            res.out_x     = ox[CoordW-1:0];
            res.out_y     = oy[CoordW-1:0];
            res.out_w     = sat_len(ow);
            res.out_h     = sat_len(oh);
            res.out_color = cmd.color;
        end else begin
            res.out_x     = '0;
            res.out_y     = '0;
            res.out_w     = '0;
            res.out_h     = '0;
            res.out_color = '0;
        end
    end

endmodule

// File: design/draw_command_clip_window_top.sv
// Path: input register, clip, result register; m_tvalid is driven by the result register,
// which loads from the input register whenever the result stage is free.
// Throughput: one item per cycle unless m_tready stalls the output; the clip logic
// between the two registers is a handful of 18-bit adds and compares.
// Reset (aresetn low, synchronous): both stages empty, clip window returns to
// left 0, top 0, right 130, bottom 130.
`include "draw_command_clip_window_top_macros.svh"

module draw_command_clip_window_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Command input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // pos_x, pos_y, span_w, span_h, color
    input  logic [1:0]  s_tuser,   // req_type
    // Clipped result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_x, out_y, out_w, out_h, out_color
    output logic [2:0]  m_tuser    // draw, out_type
);
    import dccw_pkg::*;

    window_t window;
    cmd_t    in_cmd_reg;
    cmd_t    in_cmd_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t clip_res;
    result_t out_res_reg;
    result_t out_res_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_ready;

    dccw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .window    (window)
    );

    dccw_clip_core u_clip (
        .cmd    (in_cmd_reg),
        .window (window),
        .res    (clip_res)
    );

    // Stage handshakes: each stage loads when it is empty or drains this cycle
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    // Input stage
    always_comb begin
        in_valid_next = in_valid_reg;
        in_cmd_next   = in_cmd_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_cmd_next.kind   = cmd_kind_e'(s_tuser);
            in_cmd_next.pos_x  = s_tdata[15:0];
            in_cmd_next.pos_y  = s_tdata[31:16];
            in_cmd_next.span_w = s_tdata[47:32];
            in_cmd_next.span_h = s_tdata[63:48];
            in_cmd_next.color  = s_tdata[79:64];
        end
    end

    // Result stage
    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_ready) begin
            out_valid_next = in_valid_reg;
            if (in_valid_reg) begin
                out_res_next = clip_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        in_cmd_reg  <= in_cmd_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.out_color, out_res_reg.out_h, out_res_reg.out_w,
                       out_res_reg.out_y, out_res_reg.out_x};
    assign m_tuser  = {out_res_reg.out_type, out_res_reg.draw};

    // A clipped item moving forward shows up at the output next cycle
    `DCCW_ASSERT_NXT(a_fwd_to_out, aclk, aresetn, in_valid_reg && out_ready, m_tvalid)
    // A full pipeline under output stall takes no new item
    `DCCW_ASSERT_IMP(a_stall_blocks, aclk, aresetn, m_tvalid && !m_tready && in_valid_reg, !s_tready)
    // Dropped commands carry an all-zero payload
    `DCCW_ASSERT_IMP(a_drop_zero, aclk, aresetn, m_tvalid && !out_res_reg.draw, m_tdata == '0)
    // Pixels never report a size
    `DCCW_ASSERT_IMP(a_pixel_nosize, aclk, aresetn,
        m_tvalid && out_res_reg.out_type == KIND_PIXEL,
        out_res_reg.out_w == '0 && out_res_reg.out_h == '0)

endmodule

// File: test/tb_draw_command_clip_window_top.sv
// Testbench for draw_command_clip_window_top: directed and random draw commands,
// clipped against a range of windows and checked against an in-bench clip predictor.
// Depends on dccw_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_draw_command_clip_window_top;
    import dccw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_CLIP_LEFT;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // pos_x, pos_y, span_w, span_h, color
    logic [1:0]  s_tuser = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;        // out_x, out_y, out_w, out_h, out_color
    logic [2:0]  m_tuser;        // draw, out_type

    // Bench copy of the clip window, updated at each register write
    window_t clip_win = '{left: CLIP_LEFT_RST, top: CLIP_TOP_RST,
                          right: CLIP_RIGHT_RST, bottom: CLIP_BOTTOM_RST};
    result_t pending_clips[$];
    result_t exp_clip;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    int      hold_request = 0;
    int      hold_left = 0;
    int      rx_mode_left = 0;
    rx_mode_e rx_mode = RX_FREE;

    draw_command_clip_window_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Clip predictor
    // ---------------------------------------------------------------

    // Length clamp to the unsigned 16-bit result range
    function automatic logic [15:0] clamp_len(input int v);
        logic [15:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 65535) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Trim a run [p, p+n] to [lo, hi]; returns 0 when nothing is left
    function automatic bit trim_span(inout int p, inout int n, input int lo, input int hi);
        if (p < lo) begin
            if (p + n < lo) return 1'b0;
            n = n - (lo - p);
            p = lo;
        end
        if (hi < p + n) begin
            if (hi < p) return 1'b0;
            n = hi - p;
        end
        return 1'b1;
    endfunction

    function automatic result_t clip_command(input cmd_t c, input window_t win);
        int x, y, w, h, x1, y1;
        int ox, oy, ow, oh;
        int l, t, r, b;
        bit keep;
        result_t res;
        x = c.pos_x;
        y = c.pos_y;
        w = c.span_w;
        h = c.span_h;
        l = win.left;
        t = win.top;
        r = win.right;
        b = win.bottom;
        keep = 1'b0;
        ox = 0;
        oy = 0;
        ow = 0;
        oh = 0;
        case (c.kind)
            KIND_PIXEL: begin
                keep = (l <= x) && (x <= r) && (t <= y) && (y <= b);
                ox = x;
                oy = y;
            end
            KIND_HLINE: begin
                if (t <= y && y <= b) keep = trim_span(x, w, l, r);
                ox = x;
                oy = y;
                ow = w;
            end
            KIND_VLINE: begin
                if (l <= x && x <= r) keep = trim_span(y, h, t, b);
                ox = x;
                oy = y;
                oh = h;
            end
            default: begin
                // rectangle: inclusive overlap, then intersect
                x1 = x + w;
                y1 = y + h;
                keep = (x <= r) && (x1 >= l) && (y <= b) && (y1 >= t);
                ox = (x < l) ? l : x;
                oy = (y < t) ? t : y;
                if (x1 > r) x1 = r;
                if (y1 > b) y1 = b;
                ow = x1 - ox;
                oh = y1 - oy;
            end
        endcase
        res = '0;
        res.out_type = c.kind;
        if (keep) begin
            res.draw = 1'b1;
            res.out_x = ox[15:0];
            res.out_y = oy[15:0];
            res.out_w = clamp_len(ow);
            res.out_h = clamp_len(oh);
            res.out_color = c.color;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%h, got 0x%h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_clips.size() == 0) begin
                $error("result item with no command outstanding");
                mismatch_count++;
            end else begin
                exp_clip = pending_clips.pop_front();
                check_field("draw", 16'(exp_clip.draw), 16'(m_tuser[0]));
                check_field("out_type", 16'(exp_clip.out_type), 16'(m_tuser[2:1]));
                check_field("out_x", exp_clip.out_x, m_tdata[15:0]);
                check_field("out_y", exp_clip.out_y, m_tdata[31:16]);
                check_field("out_w", exp_clip.out_w, m_tdata[47:32]);
                check_field("out_h", exp_clip.out_h, m_tdata[63:48]);
                check_field("out_color", exp_clip.out_color, m_tdata[79:64]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall patterns plus an on-demand long hold
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 160);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_FREE:   m_tready <= 1'b1;
                RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ((cycle_count % 5) < 3);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Send one command; bursts of random length with random gaps between them
    task automatic send_cmd(input cmd_kind_e kind, input int x, input int y,
                            input int w, input int h, input logic [15:0] color);
        cmd_t c;
        int gap;
        c.kind = kind;
        c.pos_x = x[15:0];
        c.pos_y = y[15:0];
        c.span_w = w[15:0];
        c.span_h = h[15:0];
        c.color = color;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {c.color, c.span_h, c.span_w, c.pos_y, c.pos_x};
        s_tuser <= c.kind;
        do @(posedge aclk); while (!s_tready);
        pending_clips.push_back(clip_command(c, clip_win));
    endtask

    // Stop sending and wait until every outstanding result has come back
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_clips.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write; valid stays high for a following write
    task automatic write_reg(input cfg_index_e idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CLIP_LEFT:  clip_win.left = value[15:0];
            REG_CLIP_TOP:   clip_win.top = value[15:0];
            REG_CLIP_RIGHT: clip_win.right = value[15:0];
            default:        clip_win.bottom = value[15:0];
        endcase
    endtask

    // Only called with the block drained
    task automatic set_window(input int l, input int t, input int r, input int b);
        write_reg(REG_CLIP_LEFT, l);
        write_reg(REG_CLIP_TOP, t);
        write_reg(REG_CLIP_RIGHT, r);
        write_reg(REG_CLIP_BOTTOM, b);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Random item shaping
    // ---------------------------------------------------------------

    function automatic int clamp16(input int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic int rand_s16();
        logic signed [15:0] s;
        s = 16'($urandom_range(0, 65535));
        return s;
    endfunction

    // Coordinate biased toward the window and its edges
    function automatic int rand_coord(input int lo, input int hi);
        int a, b, v;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        a = ((lo < hi) ? lo : hi) - 16;
        b = ((lo < hi) ? hi : lo) + 16;
        if (sel <= 3) begin
            v = $urandom_range(0, b - a);
            v = a + v;
        end else if (sel <= 5) begin
            v = $urandom_range(0, 4);
            v = ((sel == 4) ? lo : hi) + v - 2;
        end else if (sel <= 7) begin
            v = rand_s16();
        end else if (sel == 8) begin
            v = $urandom_range(0, 1) ? 32767 : -32768;
        end else begin
            v = $urandom_range(0, 6);
            v = v - 3;
        end
        return clamp16(v);
    endfunction

    function automatic int rand_span();
        int v;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            v = $urandom_range(0, 180);
            v = v - 20;
        end else if (sel <= 7) begin
            v = rand_s16();
        end else if (sel == 8) begin
            case ($urandom_range(0, 3))
                0:       v = 32767;
                1:       v = -32768;
                2:       v = 0;
                default: v = -1;
            endcase
        end else begin
            v = $urandom_range(0, 40);
            v = -v;
        end
        return v;
    endfunction

    task automatic send_random_cmd();
        int x, y;
        x = rand_coord(clip_win.left, clip_win.right);
        y = rand_coord(clip_win.top, clip_win.bottom);
        send_cmd(cmd_kind_e'($urandom_range(0, 3)), x, y, rand_span(), rand_span(),
                 16'($urandom_range(0, 65535)));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Every kind and the clip cases against the reset window [0..130]
    task automatic test_reset_window();
        // pixels: inside, both corners, outside on each axis
        send_cmd(KIND_PIXEL, 10, 20, 32767, -32768, 16'h1234);
        send_cmd(KIND_PIXEL, 0, 0, 0, 0, 16'hFFFF);
        send_cmd(KIND_PIXEL, 130, 130, 5, 5, 16'h0000);
        send_cmd(KIND_PIXEL, 131, 50, 0, 0, 16'hA5A5);
        send_cmd(KIND_PIXEL, 50, -1, 0, 0, 16'h5A5A);
        // horizontal lines: left trim, right trim, both, dropped, row outside, negative length
        send_cmd(KIND_HLINE, -10, 5, 50, 7, 16'h0F0F);
        send_cmd(KIND_HLINE, 100, 5, 100, 0, 16'hF0F0);
        send_cmd(KIND_HLINE, -10, 130, 200, 0, 16'h8001);
        send_cmd(KIND_HLINE, -100, 5, 10, 0, 16'h1111);
        send_cmd(KIND_HLINE, 200, 5, 10, 0, 16'h2222);
        send_cmd(KIND_HLINE, 10, 200, 10, 0, 16'h3333);
        send_cmd(KIND_HLINE, 50, 5, -20, 0, 16'h4444);
        // vertical lines
        send_cmd(KIND_VLINE, 5, -10, 9, 50, 16'h5555);
        send_cmd(KIND_VLINE, 5, 100, 0, 100, 16'h6666);
        send_cmd(KIND_VLINE, 200, 5, 0, 10, 16'h7777);
        send_cmd(KIND_VLINE, 5, 50, 0, -20, 16'h8888);
        // rectangles: wholly inside, overlapping, outside, inverted size
        send_cmd(KIND_RECT, 10, 10, 20, 20, 16'h9999);
        send_cmd(KIND_RECT, -10, -10, 50, 300, 16'hAAAA);
        send_cmd(KIND_RECT, 200, 200, 5, 5, 16'hBBBB);
        send_cmd(KIND_RECT, 50, 50, -10, -10, 16'hCCCC);
        // field extremes
        send_cmd(KIND_PIXEL, -32768, 32767, 32767, -32768, 16'hFFFF);
        send_cmd(KIND_HLINE, -32768, 10, 32767, -32768, 16'hDDDD);
        send_cmd(KIND_RECT, -32768, -32768, 32767, 32767, 16'hFFFF);
        send_cmd(KIND_VLINE, 32767, 32767, -32768, -32768, 16'h0001);
        wait_results_done();
    endtask

    // Full-range, inverted and single-pixel windows
    task automatic test_window_extremes();
        set_window(-32768, -32768, 32767, 32767);
        send_cmd(KIND_RECT, -32768, -32768, 32767, 32767, 16'hFFFF);
        send_cmd(KIND_RECT, 32767, 32767, -32768, -32768, 16'h8000);
        send_cmd(KIND_HLINE, -32768, 0, -32768, 0, 16'h0002);
        send_cmd(KIND_VLINE, 32767, -32768, 0, 32767, 16'h0004);
        wait_results_done();
        set_window(100, 100, 10, 10);
        send_cmd(KIND_PIXEL, 50, 50, 0, 0, 16'h0008);
        send_cmd(KIND_HLINE, 0, 50, 200, 0, 16'h0010);
        send_cmd(KIND_RECT, 0, 0, 200, 200, 16'h0020);
        wait_results_done();
        set_window(5, 7, 5, 7);
        send_cmd(KIND_PIXEL, 5, 7, 0, 0, 16'h0040);
        send_cmd(KIND_VLINE, 5, 0, 0, 20, 16'h0080);
        send_cmd(KIND_RECT, 0, 0, 10, 10, 16'h0100);
        wait_results_done();
    endtask

    // Long receiver hold while the sender keeps offering items
    task automatic test_backpressure();
        set_window(0, 0, 130, 130);
        hold_request = 80;
        repeat (40) send_random_cmd();
        wait_results_done();
    endtask

    // Random traffic under a series of windows
    task automatic test_random_windows();
        int l, t, r, b;
        int span;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    l = 0; t = 0; r = 130; b = 130;
                end
                1: begin
                    l = -32768; t = -32768; r = 32767; b = 32767;
                end
                2: begin
                    l = $urandom_range(0, 200); t = $urandom_range(0, 200);
                    r = l - $urandom_range(1, 100); b = t - $urandom_range(1, 100);
                end
                3: begin
                    l = rand_s16(); t = rand_s16(); r = l; b = t;
                end
                4: begin
                    l = rand_s16(); t = rand_s16(); r = rand_s16(); b = rand_s16();
                end
                default: begin
                    l = $urandom_range(0, 400); l = l - 200;
                    t = $urandom_range(0, 400); t = t - 200;
                    span = $urandom_range(0, 300);
                    r = clamp16(l + span);
                    span = $urandom_range(0, 300);
                    b = clamp16(t + span);
                end
            endcase
            set_window(l, t, r, b);
            for (int n = 0; n < 280; n++) begin
                send_random_cmd();
                // mid-phase pause until the pipe is empty
                if (phase == 0 && n == 140) wait_results_done();
            end
            wait_results_done();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_window();
        test_window_extremes();
        test_backpressure();
        test_random_windows();
        wait_results_done();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/dccw_pkg.sv
design/dccw_cfg_regs.sv
design/dccw_clip_core.sv
design/draw_command_clip_window_top.sv
test/tb_draw_command_clip_window_top.sv
